// File: hw/rtl/bqm_pkg.sv
// ----------------------------------------------------------------------------
// Bound to queue map package
// Shared types, codes and helpers for the bound to queue map block.
// ----------------------------------------------------------------------------
`default_nettype none

package bqm_pkg;

	// Number of hardware queues, one table slot for each.
	localparam int QUEUES = 4;
	// Width of a slot index.
	localparam int IDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	// Widths of the request and result fields.
	localparam int REQ_W    = 2;
	localparam int BOUND_W  = 8;
	localparam int STATUS_W = 3;
	localparam int QUEUE_W  = 2;
	localparam int REFS_W   = 16;
	localparam logic [REFS_W-1:0] REFS_MAX = {REFS_W{1'b1}};

	typedef logic [IDX_W-1:0] idx_t;

	// Request kinds.
	typedef enum logic [REQ_W-1:0] {
		REQ_ADD    = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_PRESENT = 3'd1,
		ST_FULL    = 3'd2,
		ST_BUSY    = 3'd3,
		ST_MISSING = 3'd4
	} status_t;

	// Commands from the sequencer to the table datapath.
	typedef struct packed {
		logic load;  // capture the incoming request
		logic exec;  // apply the captured request and load the result
	} cmd_t;

	// The queue field carries the low bits of the slot index.
	function automatic logic [QUEUE_W-1:0] to_queue(input idx_t idx);
		logic [IDX_W+QUEUE_W-1:0] ext;
		ext = {{QUEUE_W{1'b0}}, idx};
		return ext[QUEUE_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bqm_ctrl.sv
// ----------------------------------------------------------------------------
// Bound to queue map sequencer
// Takes one request, then applies it to the table once the result register
// is free, and tracks the state of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bqm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output bqm_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   fire_exec;

	// A captured request is applied when the result register is empty or
	// is being emptied in this cycle.
	assign s_tready  = (state_q == S_IDLE);
	assign fire_exec = (state_q == S_EXEC) && (!out_valid_q || m_tready);
	assign cmd.load  = s_tvalid && s_tready;
	assign cmd.exec  = fire_exec;
	assign m_tvalid  = out_valid_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (fire_exec) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and result register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire_exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// An accepted request is worked on in the following cycle.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_EXEC))
		else $error("accepted request did not move to execute");

	// Applying a request always presents a result next.
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> m_tvalid)
		else $error("executed request left no result");

	// No request is taken while a captured one is still pending.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request accepted before execute");

endmodule

`default_nettype wire

// File: hw/rtl/bqm_table.sv
// ----------------------------------------------------------------------------
// Bound to queue map table
// Slot registers with parallel key match, lowest free slot search, count
// update and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bqm_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire bqm_pkg::cmd_t                  cmd,
	input  wire logic [bqm_pkg::REQ_W-1:0]      req_type,
	input  wire logic [bqm_pkg::BOUND_W-1:0]    bound,
	output logic [bqm_pkg::STATUS_W-1:0]        status,
	output logic [bqm_pkg::QUEUE_W-1:0]         queue,
	output logic [bqm_pkg::REFS_W-1:0]          ref_count
);

	localparam int Q = bqm_pkg::QUEUES;

	// Captured request.
	logic [bqm_pkg::REQ_W-1:0]   req_q;
	logic [bqm_pkg::BOUND_W-1:0] key_q;

	// Slot storage.
	logic [Q-1:0]                valid_q;
	logic [bqm_pkg::BOUND_W-1:0] bound_q [Q];
	logic [bqm_pkg::REFS_W-1:0]  refs_q  [Q];

	// Search results.
	logic [Q-1:0]          match_vec;
	logic                  hit;
	bqm_pkg::idx_t         hit_idx;
	logic                  has_free;
	bqm_pkg::idx_t         free_idx;
	logic [bqm_pkg::REFS_W-1:0] hit_refs;
	logic [bqm_pkg::REFS_W-1:0] inc_refs;
	logic [bqm_pkg::REFS_W-1:0] dec_refs;

	// Result of the current request.
	bqm_pkg::status_t            res_status;
	bqm_pkg::idx_t               res_idx;
	logic                        res_idx_en;
	logic [bqm_pkg::REFS_W-1:0]  res_refs;

	// Result register.
	logic [bqm_pkg::STATUS_W-1:0] status_q;
	logic [bqm_pkg::QUEUE_W-1:0]  queue_q;
	logic [bqm_pkg::REFS_W-1:0]   count_q;

	// Compare the key against every slot in parallel.
	always_comb begin
		for (int i = 0; i < Q; i++) begin
			match_vec[i] = valid_q[i] && (bound_q[i] == key_q);
		end
	end

	// Priority encoders: lowest matching slot and lowest free slot.
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		has_free = 1'b0;
		free_idx = '0;
		for (int i = Q - 1; i >= 0; i--) begin
			if (match_vec[i]) begin
				hit     = 1'b1;
				hit_idx = bqm_pkg::IDX_W'(i);
			end
			if (!valid_q[i]) begin
				has_free = 1'b1;
				free_idx = bqm_pkg::IDX_W'(i);
			end
		end
	end

	// Saturating increment and floored decrement of the matched count.
	assign hit_refs = refs_q[hit_idx];
	assign inc_refs = (hit_refs == bqm_pkg::REFS_MAX) ? hit_refs
		: hit_refs + bqm_pkg::REFS_W'(1);
	assign dec_refs = (hit_refs == '0) ? hit_refs : hit_refs - bqm_pkg::REFS_W'(1);

	// Decode the request into its result.
	always_comb begin
		res_status = bqm_pkg::ST_OK;
		res_idx    = '0;
		res_idx_en = 1'b0;
		res_refs   = '0;
		unique case (bqm_pkg::req_t'(req_q))
			bqm_pkg::REQ_ADD: begin
				if (hit) begin
					res_status = bqm_pkg::ST_PRESENT;
					res_idx    = hit_idx;
					res_idx_en = 1'b1;
					res_refs   = inc_refs;
				end else if (has_free) begin
					res_status = bqm_pkg::ST_OK;
					res_idx    = free_idx;
					res_idx_en = 1'b1;
					res_refs   = bqm_pkg::REFS_W'(1);
				end else begin
					res_status = bqm_pkg::ST_FULL;
				end
			end
			bqm_pkg::REQ_LOOKUP: begin
				if (hit) begin
					res_idx    = hit_idx;
					res_idx_en = 1'b1;
					res_refs   = hit_refs;
				end else begin
					res_status = bqm_pkg::ST_MISSING;
				end
			end
			bqm_pkg::REQ_REMOVE: begin
				if (hit) begin
					res_idx    = hit_idx;
					res_idx_en = 1'b1;
					res_refs   = dec_refs;
					res_status = (dec_refs == '0) ? bqm_pkg::ST_OK : bqm_pkg::ST_BUSY;
				end else begin
					res_status = bqm_pkg::ST_MISSING;
				end
			end
			bqm_pkg::REQ_CLEAR: begin
				res_status = bqm_pkg::ST_OK;
			end
			default: res_status = bqm_pkg::ST_OK;
		endcase
	end

	// Request capture and result register; payload only, no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			key_q <= bound;
		end
		if (cmd.exec) begin
			status_q <= res_status;
			queue_q  <= res_idx_en ? bqm_pkg::to_queue(res_idx) : '0;
			count_q  <= res_refs;
		end
	end

	// Slot valid bits and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < Q; i++) begin
				refs_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			if (req_q == bqm_pkg::REQ_CLEAR) begin
				valid_q <= '0;
				for (int i = 0; i < Q; i++) begin
					refs_q[i] <= '0;
				end
			end else if (req_q == bqm_pkg::REQ_ADD) begin
				if (hit) begin
					refs_q[hit_idx] <= inc_refs;
				end else if (has_free) begin
					valid_q[free_idx] <= 1'b1;
					refs_q[free_idx]  <= bqm_pkg::REFS_W'(1);
				end
			end else if (req_q == bqm_pkg::REQ_REMOVE && hit) begin
				refs_q[hit_idx] <= dec_refs;
				if (dec_refs == '0) valid_q[hit_idx] <= 1'b0;
			end
		end
	end

	// Bound keys are written when a new slot is taken.
	always_ff @(posedge clk) begin
		if (cmd.exec && req_q == bqm_pkg::REQ_ADD && !hit && has_free) begin
			bound_q[free_idx] <= key_q;
		end
	end

	assign status    = status_q;
	assign queue     = queue_q;
	assign ref_count = count_q;

	// Add never duplicates a key, so at most one slot can match.
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(match_vec) <= 1)
		else $error("more than one slot holds the same bound");

	// A clear empties every slot.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && req_q == bqm_pkg::REQ_CLEAR) |=> (valid_q == '0))
		else $error("clear left a slot valid");

	// A full table rejects a new bound without taking a slot.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && req_q == bqm_pkg::REQ_ADD && !hit && !has_free)
		|=> (status_q == bqm_pkg::ST_FULL) && $stable(valid_q))
		else $error("full table changed on add");

endmodule

`default_nettype wire

// File: hw/rtl/bound_to_queue_map.sv
// ----------------------------------------------------------------------------
// Bound to queue map
// Maps a bound option to a hardware queue with reference counting.
// ----------------------------------------------------------------------------
// Requests arrive on the slave stream: s_tuser carries the request kind
// (add, lookup, remove, clear) and s_tdata the bound option. Each request
// gives exactly one result on the master stream: m_tuser carries the status
// and m_tdata the queue and the slot's reference count.
// A new bound takes the lowest free queue; an add of a present bound raises
// its count, which holds at its maximum. A remove that brings the count to
// zero frees the queue.
// A request is captured, applied to the table in execute once the result
// register is free, and its result is then held in the result register.
// The sequencer accepts, then executes, and takes no new request while one
// is in execute. The result register lets the next request be accepted
// while a result still waits; that request is held in execute until the
// result is taken, and s_tready stays low meanwhile.
// Reset empties the table at once and clears all valid flags; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module bound_to_queue_map (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] bound
	input  wire logic [1:0]  s_tuser,   // [1:0] req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [1:0] queue, [17:2] ref_count, rest zero
	output logic [2:0]       m_tuser    // [2:0] status
);

	bqm_pkg::cmd_t                 cmd;
	logic [bqm_pkg::QUEUE_W-1:0]   queue;
	logic [bqm_pkg::REFS_W-1:0]    ref_count;

	// Sequencer.
	bqm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Table datapath.
	bqm_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_type  (s_tuser),
		.bound     (s_tdata),
		.status    (m_tuser),
		.queue     (queue),
		.ref_count (ref_count)
	);

	// Pack the result fields.
	assign m_tdata = {6'd0, ref_count, queue};

endmodule

`default_nettype wire
